/* sv/lmcr_pkg.sv */
// Shared types, constants and helper functions of the LED matrix column refresh block.
package lmcr_pkg;

  localparam int unsigned MaxColumnsDefault = 64;
  localparam int unsigned RowsMax           = 8;
  localparam int unsigned ColCountW         = 7;
  localparam int unsigned RowCountW         = 4;
  localparam int unsigned DataW             = 8;
  localparam int unsigned CoordW            = 16;
  localparam int unsigned ColorW            = 16;
  localparam int unsigned IndexW            = 6;
  localparam int unsigned ApbAddrW          = 3;
  localparam int unsigned ApbDataW          = 32;

  localparam logic [ColCountW-1:0] ColCountReset = 7'd64;
  localparam logic [RowCountW-1:0] RowCountReset = 4'd8;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdDraw    = 2'd1,
    CmdRefresh = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic {
    RegColumnCount = 1'b0,
    RegRowCount    = 1'b1
  } reg_e;

  typedef enum logic {
    RfIdle = 1'b0,
    RfRun  = 1'b1
  } rf_state_e;

  typedef struct packed {
    logic [ColCountW-1:0] column_count;
    logic [RowCountW-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [IndexW-1:0] index;
    logic              last;
  } out_item_t;

  // Rows in use: anything above eight behaves as eight.
  function automatic logic [RowCountW-1:0] rows_in_use(logic [RowCountW-1:0] rows);
    logic [RowCountW-1:0] r;
    r = (rows > RowCountW'(RowsMax)) ? RowCountW'(RowsMax) : rows;
    return r;
  endfunction

  // One bit set for every row in use.
  function automatic logic [DataW-1:0] row_mask(logic [RowCountW-1:0] rows);
    logic [DataW:0] m;
    m = ((DataW+1)'(1) << rows) - (DataW+1)'(1);
    return m[DataW-1:0];
  endfunction

endpackage

/* sv/lmcr_regs.sv */
// APB configuration registers: column count and row count.
module lmcr_regs import lmcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        RegColumnCount: cfg_d.column_count = pwdata[ColCountW-1:0];
        RegRowCount:    cfg_d.row_count    = pwdata[RowCountW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      RegColumnCount: prdata = ApbDataW'(cfg_q.column_count);
      RegRowCount:    prdata = ApbDataW'(cfg_q.row_count);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_count <= ColCountReset;
      cfg_q.row_count    <= RowCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/lmcr_store.sv */
// Column store: one byte per column in a synchronous memory, with per-column valid bits.
module lmcr_store import lmcr_pkg::*; #(
  parameter int unsigned Depth = MaxColumnsDefault,
  parameter int unsigned AddrW = $clog2(MaxColumnsDefault)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [DataW-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
      rvld_q  <= vld_q[rd_addr_i];
    end
  end

  // A column that has not been written since reset or the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

/* sv/lmcr_draw.sv */
// Draw pixel unit: range check, then read-modify-write of one column with forwarding.
module lmcr_draw import lmcr_pkg::*; #(
  parameter int unsigned AddrW = $clog2(MaxColumnsDefault),
  parameter int unsigned CntW  = $clog2(MaxColumnsDefault + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic                 clr_i,
  input  logic [CoordW-1:0]    pixel_x_i,
  input  logic [CoordW-1:0]    pixel_y_i,
  input  logic [ColorW-1:0]    color_i,
  input  logic [CntW-1:0]      cols_i,
  input  logic [RowCountW-1:0] rows_i,
  output logic                 rd_en_o,
  output logic [AddrW-1:0]     rd_addr_o,
  input  logic [DataW-1:0]     rd_data_i,
  output logic                 wr_en_o,
  output logic [AddrW-1:0]     wr_addr_o,
  output logic [DataW-1:0]     wr_data_o,
  output logic                 busy_o
);

  logic             x_ok, y_ok;
  logic             s1_v_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [2:0]       s1_bit_q;
  logic             s1_lit_q;
  logic             fw_v_q;
  logic [AddrW-1:0] fw_addr_q;
  logic [DataW-1:0] fw_data_q;
  logic [DataW-1:0] base, bit_sel, new_data;

  // Coordinates are signed: a set sign bit is always out of range.
  assign x_ok = !pixel_x_i[CoordW-1] && (pixel_x_i < CoordW'(cols_i));
  assign y_ok = !pixel_y_i[CoordW-1] && (pixel_y_i < CoordW'(rows_i));

  assign rd_en_o   = go_i && x_ok && y_ok;
  assign rd_addr_o = pixel_x_i[AddrW-1:0];

  // The memory returns the old byte when the previous draw wrote the same column
  // in the cycle of this read, so that write is taken from the forwarding register.
  assign base     = (fw_v_q && (fw_addr_q == s1_addr_q)) ? fw_data_q : rd_data_i;
  assign bit_sel  = DataW'(1) << s1_bit_q;
  assign new_data = s1_lit_q ? (base | bit_sel) : (base & ~bit_sel);

  assign wr_en_o   = s1_v_q;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = new_data;
  assign busy_o    = s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fw_v_q <= 1'b0;
    end else begin
      s1_v_q <= rd_en_o;
      if (clr_i) begin
        fw_v_q <= 1'b0;
      end else if (s1_v_q) begin
        fw_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_o) begin
      s1_addr_q <= pixel_x_i[AddrW-1:0];
      s1_bit_q  <= pixel_y_i[2:0];
      s1_lit_q  <= (color_i != '0);
    end
    if (s1_v_q) begin
      fw_addr_q <= s1_addr_q;
      fw_data_q <= new_data;
    end
  end

endmodule

/* sv/lmcr_refresh.sv */
// Refresh sequencer: walks the columns through the store and queues the bytes for output.
module lmcr_refresh import lmcr_pkg::*; #(
  parameter int unsigned AddrW = $clog2(MaxColumnsDefault),
  parameter int unsigned CntW  = $clog2(MaxColumnsDefault + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CntW-1:0]      cols_i,
  input  logic [RowCountW-1:0] rows_i,
  output logic                 rd_en_o,
  output logic [AddrW-1:0]     rd_addr_o,
  input  logic [DataW-1:0]     rd_data_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  rf_state_e        state_q, state_d;
  logic [CntW-1:0]  col_q, col_d;
  logic [CntW-1:0]  ncols_q, ncols_d;
  logic [DataW-1:0] mask_q, mask_d;
  logic             is_last;
  logic             issue;
  logic             take;
  logic [1:0]       occ;

  logic             rd_v_q;
  logic [IndexW-1:0] rd_idx_q;
  logic             rd_last_q;
  out_item_t        push;

  logic             out_v_q, out_v_d, sk_v_q, sk_v_d;
  out_item_t        out_q, out_d, sk_q, sk_d;

  assign take = out_v_q && !out_stall_i;
  // Entries held or in flight; a read is issued only when a slot is sure to be free.
  assign occ  = 2'(out_v_q) + 2'(sk_v_q) + 2'(rd_v_q) - 2'(take);

  assign is_last = (({1'b0, col_q} + (CntW+1)'(1)) == {1'b0, ncols_q});
  assign issue   = (state_q == RfRun) && (occ < 2'd2);

  assign rd_en_o   = issue;
  assign rd_addr_o = col_q[AddrW-1:0];
  assign busy_o    = (state_q == RfRun);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    ncols_d = ncols_q;
    mask_d  = mask_q;
    case (state_q)
      RfIdle: begin
        if (start_i && (cols_i != '0)) begin
          state_d = RfRun;
          col_d   = '0;
          ncols_d = cols_i;
          mask_d  = row_mask(rows_i);
        end
      end
      RfRun: begin
        if (issue) begin
          col_d = col_q + CntW'(1);
          if (is_last) begin
            state_d = RfIdle;
          end
        end
      end
      default: state_d = RfIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RfIdle;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    ncols_q <= ncols_d;
    mask_q  <= mask_d;
    out_q   <= out_d;
    sk_q    <= sk_d;
    if (issue) begin
      rd_idx_q  <= IndexW'(col_q);
      rd_last_q <= is_last;
    end
  end

  assign push.data  = rd_data_i & mask_q;
  assign push.index = rd_idx_q;
  assign push.last  = rd_last_q;

  // Two-entry output queue: the output register and a skid register behind it.
  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    sk_d    = sk_q;
    sk_v_d  = sk_v_q;
    if (!out_v_q || take) begin
      if (sk_v_q) begin
        out_d   = sk_q;
        out_v_d = 1'b1;
        sk_d    = push;
        sk_v_d  = rd_v_q;
      end else if (rd_v_q) begin
        out_d   = push;
        out_v_d = 1'b1;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (rd_v_q) begin
      sk_d   = push;
      sk_v_d = 1'b1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

/* sv/led_matrix_column_refresh.sv */
// Draw: a draw is read at acceptance and written back in the next cycle; draws go at one per cycle
// while no refresh is reading the store. Clear is stalled while a draw write-back is still in flight.
// Refresh: the first column byte passes the state, store read and output registers, then one
// byte per cycle while the output is not stalled, column_count bytes in all but at most the
// store depth, bounded by the single read port. Input is stalled while a refresh reads the store.
// Reset: registers return to 64 columns and 8 rows; the store reads as zeros at once.
module led_matrix_column_refresh import lmcr_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [CoordW-1:0]   pixel_x_i,
  input  logic [CoordW-1:0]   pixel_y_i,
  input  logic [ColorW-1:0]   color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DataW-1:0]    column_data_o,
  output logic [IndexW-1:0]   column_index_o,
  output logic                last_column_o
);

  localparam int unsigned AddrW = $clog2(MAX_COLUMNS);
  localparam int unsigned CntW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CmpW  = (CntW > ColCountW) ? CntW : ColCountW;

  cfg_t                 cfg;
  cmd_e                 cmd;
  logic                 accept;
  logic [CntW-1:0]      cols;
  logic [RowCountW-1:0] rows;

  logic             draw_rd_en, draw_wr_en, draw_busy;
  logic [AddrW-1:0] draw_rd_addr, draw_wr_addr;
  logic [DataW-1:0] draw_wr_data;
  logic             rf_rd_en, rf_busy;
  logic [AddrW-1:0] rf_rd_addr;
  logic [DataW-1:0] rd_data;
  logic             st_rd_en;
  logic [AddrW-1:0] st_rd_addr;
  out_item_t        out_item;

  lmcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Column counts above the store depth act as the store depth.
  assign cols = (CmpW'(cfg.column_count) > CmpW'(MAX_COLUMNS)) ? CntW'(MAX_COLUMNS)
                                                                 : CntW'(cfg.column_count);
  assign rows = rows_in_use(cfg.row_count);

  assign cmd        = cmd_e'(cmd_i);
  assign in_stall_o = rf_busy || (draw_busy && (cmd != CmdDraw));
  assign accept     = in_valid_i && !in_stall_o;

  lmcr_draw #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_draw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept && (cmd == CmdDraw)),
    .clr_i     (accept && (cmd == CmdClear)),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .color_i   (color_i),
    .cols_i    (cols),
    .rows_i    (rows),
    .rd_en_o   (draw_rd_en),
    .rd_addr_o (draw_rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (draw_wr_en),
    .wr_addr_o (draw_wr_addr),
    .wr_data_o (draw_wr_data),
    .busy_o    (draw_busy)
  );

  lmcr_refresh #(
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_refresh (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && (cmd == CmdRefresh)),
    .cols_i      (cols),
    .rows_i      (rows),
    .rd_en_o     (rf_rd_en),
    .rd_addr_o   (rf_rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (rf_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item)
  );

  // The refresh walk stalls the input, so the two never read in the same cycle.
  assign st_rd_en   = draw_rd_en || rf_rd_en;
  assign st_rd_addr = rf_rd_en ? rf_rd_addr : draw_rd_addr;

  lmcr_store #(
    .Depth (MAX_COLUMNS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (accept && (cmd == CmdClear)),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (draw_wr_en),
    .wr_addr_i (draw_wr_addr),
    .wr_data_i (draw_wr_data)
  );

  assign column_data_o  = out_item.data;
  assign column_index_o = out_item.index;
  assign last_column_o  = out_item.last;

endmodule

/* sv/lmcr_checker.sv */
// Port-level checker for the LED matrix column refresh block, bound to the top level.
module lmcr_checker import lmcr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [ApbDataW-1:0] pwdata,
  input logic                pready,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [DataW-1:0]    column_data_o,
  input logic [IndexW-1:0]   column_index_o,
  input logic                last_column_o
);

  logic [RowCountW-1:0] rows_q;
  logic [IndexW-1:0]    exp_idx_q;
  logic [DataW-1:0]     mask;

  // Shadow of the row count and of the next column index expected on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= RowCountReset;
      exp_idx_q <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (reg_e'(paddr[2]) == RegRowCount)) begin
        rows_q <= pwdata[RowCountW-1:0];
      end
      if (out_valid_o && !out_stall_i) begin
        exp_idx_q <= last_column_o ? '0 : exp_idx_q + IndexW'(1);
      end
    end
  end

  assign mask = row_mask(rows_in_use(rows_q));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(column_data_o)
      && $stable(column_index_o) && $stable(last_column_o))
    else $error("stalled output transaction changed");

  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_index_o == exp_idx_q))
    else $error("column index out of sequence");

  a_row_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((column_data_o & ~mask) == '0))
    else $error("column data has bits above the rows in use");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output transaction offered straight after reset");

endmodule

bind led_matrix_column_refresh lmcr_checker u_lmcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .pready         (pready),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .column_data_o  (column_data_o),
  .column_index_o (column_index_o),
  .last_column_o  (last_column_o)
);

/* tb/sv/led_matrix_column_refresh_test.sv */
// Self-checking testbench for the LED matrix column refresh block.
`timescale 1ns / 100ps

class column_scoreboard;
  logic [7:0]            pixels [64];
  logic [6:0]            column_reg;
  logic [3:0]            row_reg;
  lmcr_pkg::out_item_t   awaited [$];
  int unsigned           mismatches;
  int unsigned           columns_seen;

  function void restart();
    foreach (pixels[i]) pixels[i] = '0;
    column_reg   = lmcr_pkg::ColCountReset;
    row_reg      = lmcr_pkg::RowCountReset;
    mismatches   = 0;
    columns_seen = 0;
    awaited.delete();
  endfunction

  function void write_reg(lmcr_pkg::reg_e r, logic [31:0] value);
    if (r == lmcr_pkg::RegColumnCount) begin
      column_reg = value[6:0];
    end else begin
      row_reg = value[3:0];
    end
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Notes an accepted command and queues the column bytes that it must produce.
  function void note_command(lmcr_pkg::cmd_e c, logic [15:0] x, logic [15:0] y,
                             logic [15:0] colour);
    int                  cols;
    int                  rows;
    int                  xi;
    int                  yi;
    logic [8:0]          mask;
    lmcr_pkg::out_item_t item;
    cols = (column_reg > 7'd64) ? 64 : int'(column_reg);
    rows = (row_reg > 4'd8) ? 8 : int'(row_reg);
    xi   = $signed(x);
    yi   = $signed(y);
    case (c)
      lmcr_pkg::CmdClear: begin
        foreach (pixels[i]) pixels[i] = '0;
      end
      lmcr_pkg::CmdDraw: begin
        if (xi >= 0 && xi < cols && yi >= 0 && yi < rows) begin
          pixels[xi][yi] = (colour != 16'h0000);
        end
      end
      lmcr_pkg::CmdRefresh: begin
        // Bits above the rows in use are stored but never shown.
        mask = (9'd1 << rows) - 9'd1;
        for (int i = 0; i < cols; i++) begin
          item.data  = pixels[i] & mask[7:0];
          item.index = 6'(i);
          item.last  = (i + 1 == cols);
          awaited.push_back(item);
        end
      end
      default: ;
    endcase
  endfunction

  function void complain(string field, int want, int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  function void check_column(logic [7:0] data, logic [5:0] index, logic last);
    lmcr_pkg::out_item_t want;
    columns_seen++;
    if (awaited.size() == 0) begin
      complain("unexpected column byte, index", -1, index);
      return;
    end
    want = awaited.pop_front();
    if (want.data !== data) complain("column_data", want.data, data);
    if (want.index !== index) complain("column_index", want.index, index);
    if (want.last !== last) complain("last_column", want.last, last);
  endfunction
endclass

module led_matrix_column_refresh_test;
  import lmcr_pkg::*;

  localparam int unsigned ClockLimit   = 1_000_000;
  localparam int unsigned PhaseItems   = 37;
  localparam int unsigned SettleCycles = 8;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ApbAddrW-1:0] paddr          = '0;
  logic [ApbDataW-1:0] pwdata         = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [1:0]          cmd_i          = CmdClear;
  logic [CoordW-1:0]   pixel_x_i      = '0;
  logic [CoordW-1:0]   pixel_y_i      = '0;
  logic [ColorW-1:0]   color_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [DataW-1:0]    column_data_o;
  logic [IndexW-1:0]   column_index_o;
  logic                last_column_o;

  column_scoreboard board = new;

  int unsigned cycles;
  int unsigned hold_left;
  bit          quiet;
  int unsigned draws_sent;
  int unsigned refreshes_sent;
  int unsigned clears_sent;
  int unsigned unused_sent;
  int unsigned settings_used;

  led_matrix_column_refresh dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_data_o  (column_data_o),
    .column_index_o (column_index_o),
    .last_column_o  (last_column_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= ClockLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Column byte monitor; the stall after each transaction is drawn afresh.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_column(column_data_o, column_index_o, last_column_o);
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      hold_left = quiet ? 0 : $urandom_range(0, 9);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic apb_write(input reg_e r, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(r, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Clear and draw leave nothing to wait for, so spare cycles follow the last column.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic issue(input cmd_e c, input logic [15:0] x, input logic [15:0] y,
                       input logic [15:0] colour, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    color_i    <= colour;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(c, x, y, colour);
    case (c)
      CmdClear:   clears_sent++;
      CmdDraw:    draws_sent++;
      CmdRefresh: refreshes_sent++;
      default:    unused_sent++;
    endcase
  endtask

  task automatic random_phase(input logic [6:0] cols, input logic [3:0] rows);
    int unsigned done;
    int unsigned span_x;
    int unsigned span_y;
    int unsigned pick;
    int unsigned gap;
    bit          steady;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] colour;
    cmd_e        c;
    settle();
    apb_write(RegColumnCount, 32'(cols));
    apb_write(RegRowCount, 32'(rows));
    settings_used++;
    span_x = ((cols > 7'd64) ? 64 : cols) + 1;
    span_y = ((rows > 4'd8) ? 8 : rows) + 1;
    steady = 1'b0;
    done   = 0;
    while (done < PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) c = CmdClear;
      else if (pick < 80) c = CmdDraw;
      else if (pick < 94) c = CmdRefresh;
      else c = CmdNop;
      // Mostly coordinates near the configured size, now and then anything at all.
      x      = 16'($urandom_range(0, span_x));
      y      = 16'($urandom_range(0, span_y));
      colour = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
      if (c == CmdNop || $urandom_range(0, 6) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 9);
      issue(c, x, y, colour, gap);
      if (c != CmdNop) done++;
    end
  endtask

  initial begin
    board.restart();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    settings_used = 1;

    // Directed part under the reset size of 64 columns by 8 rows.
    issue(CmdRefresh, 16'h0000, 16'h0000, 16'h0000, 0);
    issue(CmdDraw, 16'd0, 16'd0, 16'h0001, 1);
    issue(CmdDraw, 16'd63, 16'd7, 16'hFFFF, 0);
    issue(CmdDraw, 16'd64, 16'd0, 16'h0001, 2);
    issue(CmdDraw, 16'hFFFF, 16'd3, 16'h0001, 0);
    issue(CmdDraw, 16'h8000, 16'd0, 16'h0001, 0);
    issue(CmdDraw, 16'h7FFF, 16'd0, 16'h0001, 1);
    issue(CmdDraw, 16'd5, 16'd8, 16'h0001, 0);
    issue(CmdDraw, 16'd5, 16'h8000, 16'h0001, 0);
    issue(CmdDraw, 16'd5, 16'h7FFF, 16'h0001, 3);
    issue(CmdDraw, 16'd5, 16'hFFFF, 16'h0001, 0);
    issue(CmdDraw, 16'd10, 16'd3, 16'h8000, 0);
    issue(CmdDraw, 16'd10, 16'd4, 16'h0001, 0);
    issue(CmdDraw, 16'd10, 16'd3, 16'h0000, 1);
    issue(CmdNop, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    issue(CmdRefresh, 16'h0000, 16'h0000, 16'h0000, 0);
    issue(CmdClear, 16'h0000, 16'h0000, 16'h0000, 2);
    issue(CmdRefresh, 16'h0000, 16'h0000, 16'h0000, 0);
    issue(CmdDraw, 16'd20, 16'd6, 16'hAAAA, 0);
    issue(CmdDraw, 16'd33, 16'd1, 16'h5555, 0);
    issue(CmdDraw, 16'd47, 16'd7, 16'h0100, 0);
    issue(CmdRefresh, 16'h0000, 16'h0000, 16'h0000, 1);

    // Sizes from the reset value through the clamped and empty extremes.
    random_phase(7'd64, 4'd8);
    random_phase(7'd8, 4'd1);
    random_phase(7'd127, 4'd15);
    random_phase(7'd13, 4'd5);
    random_phase(7'd0, 4'd3);
    random_phase(7'd40, 4'd0);
    random_phase(7'd64, 4'd9);
    random_phase(7'd24, 4'd8);
    random_phase(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    random_phase(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)));
    settle();

    $display("Sent %0d draws, %0d refreshes, %0d clears and %0d unused commands under %0d sizes.",
             draws_sent, refreshes_sent, clears_sent, unused_sent, settings_used);
    $display("Checked %0d column bytes with %0d mismatches.", board.columns_seen,
             board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
